@@ hw/rtl/mf3c_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3c_pkg
// Shared types, register indexes and the 9-input median network for the
// cropped 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3c_pkg;

  localparam int MAX_LINE_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int LW_W    = 11;   // line_width register
  localparam int SPOT_W  = 10;   // spot offsets and sizes
  localparam int ROW_W   = 11;   // camera row counter
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  localparam logic [LW_W-1:0]   LINE_WIDTH_RST  = LW_W'(640);
  localparam logic [SPOT_W-1:0] SPOT_LEFT_RST   = SPOT_W'(1);
  localparam logic [SPOT_W-1:0] SPOT_BOTTOM_RST = SPOT_W'(1);
  localparam logic [SPOT_W-1:0] SPOT_WIDTH_RST  = SPOT_W'(64);
  localparam logic [SPOT_W-1:0] SPOT_HEIGHT_RST = SPOT_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH  = 3'd0,
    CFG_SPOT_LEFT   = 3'd1,
    CFG_SPOT_BOTTOM = 3'd2,
    CFG_SPOT_WIDTH  = 3'd3,
    CFG_SPOT_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  median;
    logic [SPOT_W-1:0] out_row;
    logic [SPOT_W-1:0] out_col;
    logic              last_of_spot;
  } out_t;

  // window taps: rows of three, oldest camera row first, left column first
  typedef logic [8:0][PIX_W-1:0] win_t;

  // compare-exchange pairs of the 19-stage median-of-9 network
  localparam int NET_LEN = 19;
  localparam int NET_A [NET_LEN] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int NET_B [NET_LEN] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  function automatic logic [PIX_W-1:0] median9(input win_t w);
    logic [PIX_W-1:0] p [9];
    logic [PIX_W-1:0] t;
    for (int i = 0; i < 9; i++) begin
      p[i] = w[i];
    end
    for (int k = 0; k < NET_LEN; k++) begin
      if (p[NET_A[k]] > p[NET_B[k]]) begin
        t           = p[NET_A[k]];
        p[NET_A[k]] = p[NET_B[k]];
        p[NET_B[k]] = t;
      end
    end
    return p[4];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mf3c_raster_cnt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3c_raster_cnt
// Camera column/row position tracker. Gives the position of the pixel in
// the current input transaction and advances when it is accepted.
// ----------------------------------------------------------------------------
module mf3c_raster_cnt #(
  parameter int MAX_LINE = mf3c_pkg::MAX_LINE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            acc,
  input  wire logic                            frame_start,
  input  wire logic [mf3c_pkg::LW_W-1:0]       line_width,
  output logic      [$clog2(MAX_LINE)-1:0]     x_cur,
  output logic      [mf3c_pkg::ROW_W-1:0]      y_cur
);
  import mf3c_pkg::*;

  localparam int XW   = $clog2(MAX_LINE);
  localparam int CMPW = ((XW > LW_W) ? XW : LW_W) + 1;

  logic [XW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             wrap;

  assign x_cur = frame_start ? '0 : col_r;
  assign y_cur = frame_start ? '0 : row_r;

  // end of line at the programmed width, or at the line store depth
  assign wrap = ((CMPW'(x_cur) + CMPW'(1)) >= CMPW'(line_width)) ||
                (x_cur == XW'(MAX_LINE - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = (y_cur == ROW_SAT) ? y_cur : y_cur + ROW_W'(1);
      end else begin
        col_nxt = x_cur + XW'(1);
        row_nxt = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mf3c_line_win.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3c_line_win
// Two line stores and the 3x3 window. Line stores are read when a pixel is
// accepted and written back when that pixel leaves the first stage, with a
// one-deep bypass for a read of the address being written.
// ----------------------------------------------------------------------------
module mf3c_line_win #(
  parameter int MAX_LINE = mf3c_pkg::MAX_LINE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_LINE)-1:0]   rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_LINE)-1:0]   wr_addr,
  input  wire logic [mf3c_pkg::PIX_W-1:0]    wr_pixel,
  output mf3c_pkg::win_t                     window
);
  import mf3c_pkg::*;

  logic [PIX_W-1:0] mem_prev  [MAX_LINE];
  logic [PIX_W-1:0] mem_prev2 [MAX_LINE];

  logic [PIX_W-1:0] rd_prev_r, rd_prev2_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_prev_r, byp_prev2_r;
  logic [PIX_W-1:0] prev_eff, prev2_eff;
  win_t             win_r, win_nxt;

  assign prev_eff  = byp_r ? byp_prev_r  : rd_prev_r;
  assign prev2_eff = byp_r ? byp_prev2_r : rd_prev2_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prev_r  <= mem_prev[rd_addr];
      rd_prev2_r <= mem_prev2[rd_addr];
    end
    if (wr_en) begin
      mem_prev[wr_addr]  <= wr_pixel;
      mem_prev2[wr_addr] <= prev_eff;
    end
  end

  // read and write of the same column at one edge: memory returns stale data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_prev_r  <= wr_pixel;
      byp_prev2_r <= prev_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (wr_en) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = prev2_eff;
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[5] = prev_eff;
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
      win_nxt[8] = wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign window = win_r;

endmodule
`default_nettype wire

@@ hw/rtl/median_filter_3x3_window_crop.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_window_crop
// 3x3 median filter over a cropped spot rectangle of a raster pixel stream.
// ----------------------------------------------------------------------------
//   in_*  : one camera pixel per transaction, raster order; frame_start on
//           the first pixel of a frame resets the column/row position.
//   out_* : zero or one result per pixel: the median of the 3x3 window
//           centered one row up and one column left of the pixel just taken,
//           for every position inside the spot rectangle, with its spot
//           row/column and a last-of-spot flag.
//   cfg_* : register writes (line_width, spot_left, spot_bottom, spot_width,
//           spot_height by index), always ready; write only while idle.
// Throughput is one pixel per clock unless the receiver stalls. The pixel
//   that completes a window passes the first stage, with the line store
//   read, and then the window stage; its result is loaded into the result
//   register through the median network and shown on out_valid.
// When the receiver stalls, one result waits in the output register, one in
//   the window stage and one pixel in the input stage; in_ready then drops.
// Reset clears position counters, window and control; configuration goes to
//   its defaults. Line stores hold no reset value.
// ----------------------------------------------------------------------------
module median_filter_3x3_window_crop #(
  parameter int MAX_LINE = mf3c_pkg::MAX_LINE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mf3c_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mf3c_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mf3c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mf3c_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import mf3c_pkg::*;

  localparam int XW = $clog2(MAX_LINE);
  localparam int CW = ((XW > SPOT_W) ? XW : SPOT_W) + 1;
  localparam int RW = ROW_W + 1;

  // configuration
  logic [LW_W-1:0]   line_width_r;
  logic [SPOT_W-1:0] spot_left_r, spot_bottom_r, spot_width_r, spot_height_r;

  // handshake
  logic acc, s1_go, s2_free, out_load;

  // first stage: accepted pixel and its position
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [XW-1:0]    s1_x_r;
  logic [ROW_W-1:0] s1_y_r;
  logic [XW-1:0]    x_cur;
  logic [ROW_W-1:0] y_cur;

  // spot position of the window
  logic [CW-1:0]    c_full;
  logic [RW-1:0]    r_full;
  logic             emit, last;

  // second stage: window holds the taps, result metadata here
  logic              s2_valid_r;
  logic [SPOT_W-1:0] s2_row_r, s2_col_r;
  logic              s2_last_r;
  win_t              window;

  logic out_valid_r;
  out_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= LINE_WIDTH_RST;
      spot_left_r   <= SPOT_LEFT_RST;
      spot_bottom_r <= SPOT_BOTTOM_RST;
      spot_width_r  <= SPOT_WIDTH_RST;
      spot_height_r <= SPOT_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:  line_width_r  <= cfg_data;
        CFG_SPOT_LEFT:   spot_left_r   <= cfg_data[SPOT_W-1:0];
        CFG_SPOT_BOTTOM: spot_bottom_r <= cfg_data[SPOT_W-1:0];
        CFG_SPOT_WIDTH:  spot_width_r  <= cfg_data[SPOT_W-1:0];
        CFG_SPOT_HEIGHT: spot_height_r <= cfg_data[SPOT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_load;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign acc      = in_valid && in_ready;

  mf3c_raster_cnt #(
    .MAX_LINE (MAX_LINE)
  ) u_cnt (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .frame_start (in_data.frame_start),
    .line_width  (line_width_r),
    .x_cur       (x_cur),
    .y_cur       (y_cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pixel_r <= in_data.pixel;
      s1_x_r     <= x_cur;
      s1_y_r     <= y_cur;
    end
  end

  mf3c_line_win #(
    .MAX_LINE (MAX_LINE)
  ) u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (acc),
    .rd_addr  (x_cur),
    .wr_en    (s1_go),
    .wr_addr  (s1_x_r),
    .wr_pixel (s1_pixel_r),
    .window   (window)
  );

  // window center is camera (y-1, x-1); spot position is offset from it
  assign c_full = CW'(s1_x_r) - CW'(spot_left_r) - CW'(1);
  assign r_full = RW'(s1_y_r) - RW'(spot_bottom_r) - RW'(1);
  assign emit   = (CW'(s1_x_r) > CW'(spot_left_r)) && (c_full < CW'(spot_width_r)) &&
                  (RW'(s1_y_r) > RW'(spot_bottom_r)) && (r_full < RW'(spot_height_r));
  assign last   = (c_full == CW'(spot_width_r) - CW'(1)) &&
                  (r_full == RW'(spot_height_r) - RW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= emit;
    end else if (out_load) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_row_r  <= r_full[SPOT_W-1:0];
      s2_col_r  <= c_full[SPOT_W-1:0];
      s2_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid_r) begin
      out_data_r.median       <= median9(window);
      out_data_r.out_row      <= s2_row_r;
      out_data_r.out_col      <= s2_col_r;
      out_data_r.last_of_spot <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ test/median_filter_3x3_window_crop_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_window_crop_tb
// Drives raster pixel streams through the cropped 3x3 median filter. A local
// model of the line stores, window and position counters predicts each median
// with its spot coordinates. A monitor compares every output transaction
// field by field. The run covers directed corner cases, then four idle/stall
// phases of randomized frames.
// ----------------------------------------------------------------------------
module median_filter_3x3_window_crop_tb;
  import mf3c_pkg::*;

  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PIXELS = 400;

  typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_NARROW} pix_mode_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  median_filter_3x3_window_crop i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // filter model state
  logic [LW_W-1:0]   lw_reg     = LINE_WIDTH_RST;
  logic [SPOT_W-1:0] left_reg   = SPOT_LEFT_RST;
  logic [SPOT_W-1:0] bottom_reg = SPOT_BOTTOM_RST;
  logic [SPOT_W-1:0] width_reg  = SPOT_WIDTH_RST;
  logic [SPOT_W-1:0] height_reg = SPOT_HEIGHT_RST;
  logic [PIX_W-1:0]  line_above  [MAX_LINE_DEF];
  logic [PIX_W-1:0]  line_above2 [MAX_LINE_DEF];
  logic [PIX_W-1:0]  win_px [9];
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  out_t        expected_medians [$];
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  pix_mode_t   pix_mode      = PIX_UNIFORM;
  int unsigned pixels_sent   = 0;
  int unsigned frames_sent   = 0;
  int unsigned medians_seen  = 0;
  int unsigned reg_writes    = 0;
  int unsigned error_cnt     = 0;

  initial begin
    for (int i = 0; i < MAX_LINE_DEF; i++) begin
      line_above[i]  = '0;
      line_above2[i] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      win_px[i] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d medians still pending", $time, expected_medians.size());
    $display("median_filter_3x3_window_crop_tb: errors");
    $finish;
  end

  // rank-based median: the element with at most four smaller and at least five
  // smaller-or-equal values
  function automatic logic [PIX_W-1:0] median_of_nine(input logic [PIX_W-1:0] w [9]);
    int lt;
    int le;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 9; j++) begin
        if (w[j] < w[i]) lt++;
        if (w[j] <= w[i]) le++;
      end
      if (lt <= 4 && le >= 5) return w[i];
    end
    return '0;
  endfunction

  function automatic void predict_median(input in_t item);
    int unsigned eff_width;
    int unsigned x;
    int          r;
    int          c;
    out_t        res;
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    eff_width = (int'(lw_reg) > MAX_LINE_DEF) ? MAX_LINE_DEF : int'(lw_reg);
    if (col_pos >= MAX_LINE_DEF) col_pos = 0;
    x = col_pos;
    for (int k = 0; k < 3; k++) begin
      win_px[k*3]   = win_px[k*3+1];
      win_px[k*3+1] = win_px[k*3+2];
    end
    win_px[2] = line_above2[x];
    win_px[5] = line_above[x];
    win_px[8] = item.pixel;
    line_above2[x] = line_above[x];
    line_above[x]  = item.pixel;
    // window center sits one row up and one column left of the new pixel
    r = int'(row_pos) - 1 - int'(bottom_reg);
    c = int'(x) - 1 - int'(left_reg);
    if (r >= 0 && c >= 0 && r < int'(height_reg) && c < int'(width_reg)) begin
      res.median       = median_of_nine(win_px);
      res.out_row      = SPOT_W'(r);
      res.out_col      = SPOT_W'(c);
      res.last_of_spot = (r == int'(height_reg) - 1) && (c == int'(width_reg) - 1);
      expected_medians.push_back(res);
    end
    if (x + 1 >= eff_width) begin
      col_pos = 0;
      if (row_pos < int'(ROW_SAT)) row_pos++;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case (pix_mode)
      PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_NARROW: return PIX_W'(100 + $urandom_range(3));
      default:    return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= out_stall_pct);
  end

  task automatic report_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      error_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result, expected none, got median %0d row %0d col %0d",
                 $time, out_data.median, out_data.out_row, out_data.out_col);
        error_cnt++;
      end else begin
        want = expected_medians.pop_front();
        report_field("median", want.median, out_data.median);
        report_field("out_row", want.out_row, out_data.out_row);
        report_field("out_col", want.out_col, out_data.out_col);
        report_field("last_of_spot", want.last_of_spot, out_data.last_of_spot);
        medians_seen++;
      end
    end
  end

  // ------------------------------------------------------------------ sender
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    in_t item;
    item.pixel       = px;
    item.frame_start = fs;
    while (int'($urandom_range(99)) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_median(item);
    pixels_sent++;
  endtask

  task automatic send_run(input int unsigned n, input bit start_frame);
    if (start_frame) frames_sent++;
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(rand_pixel(), start_frame && i == 0);
    end
  endtask

  // also covers pixels that produce no result but may still be in flight
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_LINE_WIDTH:  lw_reg     = LW_W'(val);
      CFG_SPOT_LEFT:   left_reg   = SPOT_W'(val);
      CFG_SPOT_BOTTOM: bottom_reg = SPOT_W'(val);
      CFG_SPOT_WIDTH:  width_reg  = SPOT_W'(val);
      CFG_SPOT_HEIGHT: height_reg = SPOT_W'(val);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input bit with_line, input int unsigned lw, input int unsigned sl,
                           input int unsigned sb, input int unsigned sw, input int unsigned sh);
    drain_pipeline();
    if (with_line) write_reg(CFG_LINE_WIDTH, lw);
    write_reg(CFG_SPOT_LEFT, sl);
    write_reg(CFG_SPOT_BOTTOM, sb);
    write_reg(CFG_SPOT_WIDTH, sw);
    write_reg(CFG_SPOT_HEIGHT, sh);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  // ------------------------------------------------------------------- tests
  // reset values: 640-pixel lines, 64x64 spot at offset (1,1)
  task automatic test_reset_defaults();
    set_idling(0, 0);
    pix_mode = PIX_UNIFORM;
    send_run(2 * 640 + 66, 1'b1);
  endtask

  task automatic test_pixel_extremes();
    logic [PIX_W-1:0] pattern [16] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
                                       8'd0, 8'd1, 8'd254, 8'd128, 8'd127, 8'd255, 8'd255,
                                       8'd0, 8'd0};
    set_idling(36, 36);
    configure(1'b1, 4, 1, 1, 2, 2);
    frames_sent++;
    for (int i = 0; i < 16; i++) begin
      send_pixel(pattern[i], i == 0);
    end
  endtask

  // line widths 0 and 1 wrap on every pixel, line width 2 on every second pixel
  task automatic test_short_lines();
    set_idling(36, 36);
    pix_mode = PIX_UNIFORM;
    for (int lw = 0; lw < 3; lw++) begin
      configure(1'b1, lw, 1, 1, 4, 4);
      send_run(6, 1'b1);
    end
  endtask

  task automatic test_empty_spot();
    set_idling(36, 36);
    configure(1'b1, 3, 1, 1, 0, 4);
    send_run(12, 1'b1);
    configure(1'b1, 3, 1, 1, 4, 0);
    send_run(12, 1'b1);
  endtask

  // spot wider than what fits in the line: last_of_spot never shows up
  task automatic test_spot_past_line_end();
    set_idling(36, 36);
    configure(1'b1, 5, 2, 1, 4, 2);
    send_run(20, 1'b1);
  endtask

  task automatic test_missing_frame_start();
    set_idling(36, 36);
    configure(1'b1, 3, 1, 1, 1, 4);
    send_run(9, 1'b1);
    send_run(9, 1'b0);
  endtask

  // first frame fills the line stores so the zero-offset frame reads only
  // written entries and the previous line's tail
  task automatic test_zero_offsets();
    set_idling(36, 36);
    configure(1'b1, 4, 1, 1, 4, 4);
    send_run(16, 1'b1);
    configure(1'b1, 4, 0, 0, 4, 4);
    send_run(16, 1'b1);
  endtask

  task automatic random_setup();
    int unsigned lw;
    int unsigned sl;
    int unsigned sb;
    int unsigned sw;
    int unsigned sh;
    lw = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
    sl = ($urandom_range(9) == 0) ? 1022 : $urandom_range(1, lw);
    sb = ($urandom_range(9) == 0) ? 1022 : $urandom_range(1, 4);
    sw = ($urandom_range(9) == 0) ? 1022 : $urandom_range(1, lw);
    sh = ($urandom_range(9) == 0) ? 1022 : $urandom_range(1, 6);
    if ($urandom_range(29) == 0) sw = 0;
    if ($urandom_range(29) == 0) sh = 0;
    configure(1'b1, lw, sl, sb, sw, sh);
  endtask

  task automatic test_random_frames();
    int          in_pct  [4] = '{0, 56, 0, 36};
    int          out_pct [4] = '{0, 0, 56, 36};
    int unsigned phase_end;
    int unsigned n;
    int unsigned stop_at;
    int unsigned restart_at;
    int unsigned retune_at;
    bit          start;
    bit          fresh;
    fresh = 1'b1;
    for (int p = 0; p < 4; p++) begin
      set_idling(in_pct[p], out_pct[p]);
      phase_end = pixels_sent + RANDOM_PIXELS / 4;
      while (pixels_sent < phase_end) begin
        // a line width change always comes with a new frame
        if (fresh || $urandom_range(99) < 70) begin
          random_setup();
          start = 1'b1;
          fresh = 1'b0;
        end else begin
          start = ($urandom_range(99) < 75);
        end
        pix_mode   = pix_mode_t'($urandom_range(2));
        n          = int'(lw_reg) * $urandom_range(3, 10);
        stop_at    = ($urandom_range(99) < 10) ? $urandom_range(1, n - 1) : n;
        restart_at = ($urandom_range(99) < 6) ? $urandom_range(1, n - 1) : 0;
        retune_at  = ($urandom_range(99) < 8) ? $urandom_range(1, n - 1) : 0;
        if (start) frames_sent++;
        for (int unsigned i = 0; i < stop_at; i++) begin
          if (i != 0 && i == retune_at) begin
            configure(1'b0, 0, $urandom_range(1, int'(lw_reg)), $urandom_range(1, 3),
                      $urandom_range(1, int'(lw_reg)), $urandom_range(1, 6));
          end
          send_pixel(rand_pixel(), (i == 0 && start) || (i != 0 && i == restart_at));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_pixel_extremes();
    test_short_lines();
    test_empty_spot();
    test_spot_past_line_end();
    test_missing_frame_start();
    test_zero_offsets();
    test_random_frames();
    set_idling(0, 0);
    drain_pipeline();
    $display("%0d pixels in %0d frames sent, %0d register writes, %0d medians checked",
             pixels_sent, frames_sent, reg_writes, medians_seen);
    $display("mismatches and unexpected results: %0d", error_cnt);
    if (error_cnt == 0) begin
      $display("median_filter_3x3_window_crop_tb: clean");
    end else begin
      $display("median_filter_3x3_window_crop_tb: errors");
    end
    $finish;
  end

endmodule
